[hdl/cmmf_pkg.sv]
// Shared types and widths for the constant modulo magic finder.
package cmmf_pkg;

    localparam int DIV_W   = 32;
    localparam int SHIFT_W = 7;
    localparam int MULT_W  = 35;

    typedef logic [DIV_W-1:0]   div_t;
    typedef logic [DIV_W:0]     pow_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [MULT_W-1:0]  mult_t;

    // Result of one modular doubling step and the search test.
    typedef struct packed {
        div_t resid_dbl;
        logic qbit;
        logic found;
    } step_t;

endpackage

[hdl/constant_modulo_magic_finder_unit.sv]
// Top level: finds shift and multiplier for divisionless modulo by a constant.
//
// One divisor word in, one result word out. The residue 2^j mod D is built by
// modular doubling, one step per cycle, from j = 0 up to N; the subtract
// decisions of that same chain are the bits of floor(2^N / D), so the quotient
// comes for free. The shift found is N = DIVIDEND_BITS + M, with M from 0 to
// 32; a divisor below 2 returns with bad_divisor set and zero fields. in_ready
// rises again together with out_valid, so with the single doubling unit the
// next divisor is not taken until the last result is in the output register.
// A finished result waits in an output register while the next divisor is
// accepted.
module constant_modulo_magic_finder_unit #(
    parameter int DIVIDEND_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cmmf_pkg::div_t         divisor,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cmmf_pkg::shift_t       shift_amount,
    output cmmf_pkg::mult_t        multiplier,
    output logic                   bad_divisor
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;

    localparam cmmf_pkg::shift_t PRE_STEPS = cmmf_pkg::shift_t'(DIVIDEND_BITS);

    logic [1:0]        state_reg, state_next;
    cmmf_pkg::div_t    d_reg, d_next;
    logic              bad_reg, bad_next;
    cmmf_pkg::div_t    r_reg, r_next;
    cmmf_pkg::mult_t   q_reg, q_next;
    cmmf_pkg::pow_t    p_reg, p_next;
    cmmf_pkg::shift_t  cnt_reg, cnt_next;
    logic              ov_reg, ov_next;
    cmmf_pkg::shift_t  sh_reg, sh_next;
    cmmf_pkg::mult_t   mu_reg, mu_next;
    logic              bd_reg, bd_next;

    cmmf_pkg::step_t   step;
    logic              searching;
    logic              done;
    logic              slot_free;

    cmmf_moddbl u_moddbl (
        .resid   (r_reg),
        .divisor (d_reg),
        .pow     (p_reg),
        .step    (step)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ov_reg;
    assign shift_amount = sh_reg;
    assign multiplier   = mu_reg;
    assign bad_divisor  = bd_reg;

    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        bad_next   = bad_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        sh_next    = sh_reg;
        mu_next    = mu_reg;
        bd_next    = bd_reg;

        searching = (cnt_reg >= PRE_STEPS);
        done      = bad_reg || (searching && step.found);
        slot_free = !ov_reg || out_ready;

        // drop the result once taken
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    d_next     = divisor;
                    bad_next   = (divisor < cmmf_pkg::div_t'(2));
                    r_next     = cmmf_pkg::div_t'(1);
                    q_next     = '0;
                    p_next     = cmmf_pkg::pow_t'(1);
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (done)
                begin
                    // hold until the output register is free
                    if (slot_free)
                    begin
                        ov_next    = 1'b1;
                        bd_next    = bad_reg;
                        sh_next    = bad_reg ? '0 : cnt_reg;
                        mu_next    = bad_reg ? '0 : q_reg + cmmf_pkg::mult_t'(1);
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // advance one doubling; the subtract decision is a quotient bit
                    r_next   = step.resid_dbl;
                    q_next   = {q_reg[cmmf_pkg::MULT_W-2:0], step.qbit};
                    cnt_next = cnt_reg + cmmf_pkg::shift_t'(1);
                    if (searching)
                    begin
                        p_next = {p_reg[cmmf_pkg::DIV_W-1:0], 1'b0};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        bad_reg <= bad_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        mu_reg  <= mu_next;
        bd_reg  <= bd_next;
    end

endmodule

[hdl/cmmf_moddbl.sv]
// One modular doubling step of the residue and the search stop test.
module cmmf_moddbl (
    input  cmmf_pkg::div_t  resid,
    input  cmmf_pkg::div_t  divisor,
    input  cmmf_pkg::pow_t  pow,
    output cmmf_pkg::step_t step
);

    logic [cmmf_pkg::DIV_W:0] dbl;
    logic [cmmf_pkg::DIV_W:0] dbl_sub;
    logic [cmmf_pkg::DIV_W:0] sum;

    always_comb
    begin
        // resid < divisor, so one compare and subtract reduces 2*resid
        dbl     = {resid, 1'b0};
        dbl_sub = dbl - {1'b0, divisor};
        sum     = {1'b0, resid} + pow;

        step.qbit      = (dbl >= {1'b0, divisor});
        step.resid_dbl = step.qbit ? dbl_sub[cmmf_pkg::DIV_W-1:0]
                                   : dbl[cmmf_pkg::DIV_W-1:0];
        // stop once divisor <= residue + 2^m
        step.found     = ({1'b0, divisor} <= sum);
    end

endmodule

[tb/tb.sv]
// Testbench for the constant modulo magic finder: directed and random divisors.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIVIDEND_BITS = 32;
    localparam int          DRAIN_CYCLES  = DIVIDEND_BITS + 40;
    localparam int          PHASE_ITEMS   = 482;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        cmmf_pkg::shift_t shift;
        cmmf_pkg::mult_t  mult;
        logic             bad;
    } magic_t;

    typedef struct packed {
        cmmf_pkg::div_t d;
        logic           known;
        magic_t         want;
    } div_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    cmmf_pkg::div_t   divisor = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    cmmf_pkg::shift_t shift_amount;
    cmmf_pkg::mult_t  multiplier;
    logic             bad_divisor;

    magic_t      pending_magic[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;

    constant_modulo_magic_finder_unit #(
        .DIVIDEND_BITS(DIVIDEND_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .divisor(divisor),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .shift_amount(shift_amount),
        .multiplier(multiplier),
        .bad_divisor(bad_divisor)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Smallest M with D <= (2^(M+32) mod D) + 2^M, then N = M+32, K = floor(2^N/D)+1.
    function automatic magic_t find_magic(input cmmf_pkg::div_t d);
        logic [63:0]  dd;
        logic [63:0]  resid;
        logic [127:0] quo;
        int unsigned  m;
        magic_t       r;
        r = '0;
        if (d < 2)
        begin
            r.bad = 1'b1;
            return r;
        end
        dd = {32'b0, d};
        resid = (64'd1 << DIVIDEND_BITS) % dd;
        m = 0;
        while (m < 32 && dd > resid + (64'd1 << m))
        begin
            resid = (resid << 1) % dd;
            m++;
        end
        // 128-bit quotient keeps the N = 64 case exact
        quo = (128'd1 << (m + DIVIDEND_BITS)) / {64'b0, dd};
        r.shift = cmmf_pkg::shift_t'(m + DIVIDEND_BITS);
        r.mult = cmmf_pkg::mult_t'(quo + 128'd1);
        return r;
    endfunction

    function automatic cmmf_pkg::div_t pick_divisor();
        cmmf_pkg::div_t d;
        case ($urandom_range(9))
            5: d = cmmf_pkg::div_t'($urandom_range(0, 300));
            6: d = (cmmf_pkg::div_t'(1) << $urandom_range(0, 31))
                   + cmmf_pkg::div_t'($urandom_range(0, 6)) - 3;
            7: d = 32'hFFFF_FFFF - cmmf_pkg::div_t'($urandom_range(0, 1000));
            8: d = 32'h8000_0000 + cmmf_pkg::div_t'($urandom_range(0, 2000)) - 1000;
            9: d = $urandom >> $urandom_range(0, 31);
            default: d = $urandom;
        endcase
        return d;
    endfunction

    task automatic send_divisor(input cmmf_pkg::div_t d, input magic_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        divisor <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_magic.push_back(want);
    endtask

    // Hold the sender until every expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_magic.size() != 0);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        magic_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_magic.size() == 0)
            begin
                $display("%0t: unexpected result word shift %0d mult %0d bad %0b",
                         $time, shift_amount, multiplier, bad_divisor);
                mismatch_count++;
            end
            else
            begin
                want = pending_magic.pop_front();
                if (shift_amount !== want.shift)
                begin
                    $display("%0t: shift_amount expected %0d got %0d",
                             $time, want.shift, shift_amount);
                    mismatch_count++;
                end
                if (multiplier !== want.mult)
                begin
                    $display("%0t: multiplier expected %0d got %0d",
                             $time, want.mult, multiplier);
                    mismatch_count++;
                end
                if (bad_divisor !== want.bad)
                begin
                    $display("%0t: bad_divisor expected %0b got %0b",
                             $time, want.bad, bad_divisor);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("constant_modulo_magic_finder_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        div_row_t directed_rows[] = '{
            '{32'd0,          1'b1, '{7'd0,  35'd0,          1'b1}},
            '{32'd1,          1'b1, '{7'd0,  35'd0,          1'b1}},
            '{32'd2,          1'b1, '{7'd33, 35'h1_0000_0001, 1'b0}},
            '{32'd4,          1'b1, '{7'd34, 35'h1_0000_0001, 1'b0}},
            '{32'h0001_0000,  1'b1, '{7'd48, 35'h1_0000_0001, 1'b0}},
            '{32'h8000_0000,  1'b1, '{7'd63, 35'h1_0000_0001, 1'b0}},
            '{32'd3,          1'b0, '0},
            '{32'd5,          1'b0, '0},
            '{32'd7,          1'b0, '0},
            '{32'd10,         1'b0, '0},
            '{32'd641,        1'b0, '0},
            '{32'd1000,       1'b0, '0},
            '{32'd6700417,    1'b0, '0},
            '{32'h5555_5555,  1'b0, '0},
            '{32'hAAAA_AAAA,  1'b0, '0},
            '{32'h7FFF_FFFF,  1'b0, '0},
            '{32'h8000_0001,  1'b0, '0},
            '{32'hC000_0001,  1'b0, '0},
            '{32'hFFFF_FFFB,  1'b0, '0},
            '{32'hFFFF_FFFE,  1'b0, '0},
            '{32'hFFFF_FFFF,  1'b0, '0}
        };
        int idle_plan[4]  = '{0, 63, 0, 27};
        int stall_plan[4] = '{0, 0, 63, 27};
        cmmf_pkg::div_t d;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_divisor(directed_rows[i].d,
                         directed_rows[i].known ? directed_rows[i].want
                                                : find_magic(directed_rows[i].d));
        drain();

        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                d = pick_divisor();
                send_divisor(d, find_magic(d));
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("constant_modulo_magic_finder_unit regression: pass");
        else
            $display("constant_modulo_magic_finder_unit regression: fail");
        $finish;
    end

endmodule
